### design/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg: shared types, constants and helpers for the 4x4 matrix inverter
// Holds the controller/datapath command and status structs, the wide
// saturating add/subtract and the 3x3 minor address helpers.
// ----------------------------------------------------------------------------
package mi4_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WIDE           = 64;

    localparam logic signed [WIDE-1:0] WIDE_MAX = {1'b0, {(WIDE-1){1'b1}}};
    localparam logic signed [WIDE-1:0] WIDE_MIN = {1'b1, {(WIDE-1){1'b0}}};

    // which part of the run the datapath works on
    typedef enum logic [1:0] {
        PH_COF = 2'd0,
        PH_DET = 2'd1,
        PH_OUT = 2'd2
    } phase_t;

    // what the datapath does with a finished product during cofactor work
    typedef enum logic [2:0] {
        POST_P     = 3'd0,
        POST_D     = 3'd1,
        POST_T_SET = 3'd2,
        POST_T_SUB = 3'd3,
        POST_T_ADD = 3'd4
    } post_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] idx;
        logic [3:0] mstep;
        logic       load_wr;
        logic       mul_start;
        logic       post;
        logic       cof_wr;
        logic       det_clr;
        logic       div_init;
        logic       div_run;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic det_zero;
        logic div_last;
    } status_t;

    typedef struct packed {
        logic                   sat;
        logic signed [WIDE-1:0] value;
    } sat_val_t;

    // operand positions inside the 3x3 minor for one product step
    typedef struct packed {
        logic [1:0] ia;
        logic [1:0] ja;
        logic [1:0] ib;
        logic [1:0] jb;
        logic       b_is_d;
        post_t      post;
    } step_info_t;

    localparam logic [3:0] LAST_MSTEP = 4'd8;

    // saturating add or subtract on wide signed values
    function automatic sat_val_t sat_addsub(input logic signed [WIDE-1:0] a,
                                            input logic signed [WIDE-1:0] b,
                                            input logic sub);
        logic [WIDE:0] s;
        sat_val_t      r;
        if (sub) begin
            s = {a[WIDE-1], a} - {b[WIDE-1], b};
        end else begin
            s = {a[WIDE-1], a} + {b[WIDE-1], b};
        end
        r.sat   = s[WIDE] != s[WIDE-1];
        r.value = r.sat ? (s[WIDE] ? WIDE_MIN : WIDE_MAX) : s[WIDE-1:0];
        return r;
    endfunction

    // flat index of minor element (i, j) of the cofactor at (r, c)
    function automatic logic [3:0] minor_addr(input logic [1:0] r, input logic [1:0] c,
                                              input logic [1:0] i, input logic [1:0] j);
        logic [1:0] row;
        logic [1:0] col;
        row = (i >= r) ? i + 2'd1 : i;
        col = (j >= c) ? j + 2'd1 : j;
        return {row, col};
    endfunction

    // expansion of one 3x3 determinant along its first row, nine products
    function automatic step_info_t step_info(input logic [3:0] ms);
        step_info_t s;
        s = '{ia: 2'd0, ja: 2'd0, ib: 2'd0, jb: 2'd0, b_is_d: 1'b0, post: POST_P};
        unique case (ms)
            4'd0:    s = '{2'd1, 2'd1, 2'd2, 2'd2, 1'b0, POST_P};
            4'd1:    s = '{2'd1, 2'd2, 2'd2, 2'd1, 1'b0, POST_D};
            4'd2:    s = '{2'd0, 2'd0, 2'd0, 2'd0, 1'b1, POST_T_SET};
            4'd3:    s = '{2'd1, 2'd0, 2'd2, 2'd2, 1'b0, POST_P};
            4'd4:    s = '{2'd1, 2'd2, 2'd2, 2'd0, 1'b0, POST_D};
            4'd5:    s = '{2'd0, 2'd1, 2'd0, 2'd0, 1'b1, POST_T_SUB};
            4'd6:    s = '{2'd1, 2'd0, 2'd2, 2'd1, 1'b0, POST_P};
            4'd7:    s = '{2'd1, 2'd1, 2'd2, 2'd0, 1'b0, POST_D};
            4'd8:    s = '{2'd0, 2'd2, 2'd0, 2'd0, 1'b1, POST_T_ADD};
            default: s = '{2'd0, 2'd0, 2'd0, 2'd0, 1'b0, POST_P};
        endcase
        return s;
    endfunction

endpackage

### design/matrix_inverse_4x4.sv
// Sequence: sixteen elements are loaded, then the cofactors and determinant are
// computed on the shared multiplier (144 products for the cofactors, 4 for
// the determinant), a 63-bit reciprocal is divided out, and the results follow.
// One matrix at a time: no new matrix is taken until its last result is taken.
// Reset: synchronous active-low aresetn returns to loading element zero.
// ----------------------------------------------------------------------------
// matrix_inverse_4x4: 4x4 fixed-point matrix inverse by the adjugate method
// Loads sixteen elements, computes cofactors, determinant and reciprocal,
// and returns the sixteen inverse elements with singular and clip flags.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4 #(
    parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_elem_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_inv_value,
    output logic                         m_singular,
    output logic                         m_saturated,
    output logic                         m_last
);
    import mi4_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    mi4_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // storage and arithmetic
    mi4_datapath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .elem_value (s_elem_value),
        .inv_value  (m_inv_value),
        .singular   (m_singular),
        .saturated  (m_saturated),
        .last       (m_last)
    );

endmodule

### design/mi4_ram.sv
// ----------------------------------------------------------------------------
// mi4_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mi4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/mi4_mul.sv
// ----------------------------------------------------------------------------
// mi4_mul: sequential scaled multiplier with truncation and saturation
// Forms the exact 128-bit product from four 32x32 partial products, shifts
// it right toward zero and clips it to 64 bits or to DATA_WIDTH bits.
// ----------------------------------------------------------------------------
module mi4_mul #(
    parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic                            narrow,
    input  logic signed [mi4_pkg::WIDE-1:0] op_a,
    input  logic signed [mi4_pkg::WIDE-1:0] op_b,
    output logic                            done,
    output logic signed [mi4_pkg::WIDE-1:0] res,
    output logic                            res_sat
);
    import mi4_pkg::*;

    localparam int RECIP_BITS = 62 - FRAC_BITS;
    localparam logic [WIDE-1:0] NARROW_TOP = WIDE'(1) << (DATA_WIDTH - 1);
    localparam logic [WIDE-1:0] WIDE_TOP   = WIDE'(1) << (WIDE - 1);

    logic [WIDE-1:0]   ma_reg, ma_next;
    logic [WIDE-1:0]   mb_reg, mb_next;
    logic              neg_reg, neg_next;
    logic              narrow_reg, narrow_next;
    logic [2*WIDE-1:0] prod_reg, prod_next;
    logic [WIDE-1:0]   pp_reg, pp_next;
    logic [1:0]        pos_reg, pos_next;
    logic [2:0]        step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic signed [WIDE-1:0] res_reg, res_next;
    logic              sat_reg, sat_next;

    logic [31:0]       half_a;
    logic [31:0]       half_b;
    logic [2*WIDE-1:0] shifted;
    logic [WIDE-1:0]   lim;
    logic [WIDE-1:0]   lo;
    logic              over;

    // pick halves, scale and clip
    always_comb begin
        half_a  = step_reg[1] ? ma_reg[WIDE-1:32] : ma_reg[31:0];
        half_b  = step_reg[0] ? mb_reg[WIDE-1:32] : mb_reg[31:0];
        shifted = narrow_reg ? (prod_reg >> RECIP_BITS) : (prod_reg >> FRAC_BITS);
        lim     = (narrow_reg ? NARROW_TOP : WIDE_TOP) - {{(WIDE-1){1'b0}}, ~neg_reg};
        over    = (|shifted[2*WIDE-1:WIDE]) || (shifted[WIDE-1:0] > lim);
        lo      = over ? lim : shifted[WIDE-1:0];
    end

    // sequence the partial products
    always_comb begin
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        neg_next    = neg_reg;
        narrow_next = narrow_reg;
        prod_next   = prod_reg;
        pp_next     = pp_reg;
        pos_next    = pos_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        sat_next    = sat_reg;
        if (start) begin
            ma_next     = op_a[WIDE-1] ? WIDE'(-op_a) : op_a;
            mb_next     = op_b[WIDE-1] ? WIDE'(-op_b) : op_b;
            neg_next    = op_a[WIDE-1] ^ op_b[WIDE-1];
            narrow_next = narrow;
            prod_next   = '0;
            step_next   = 3'd0;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (step_reg <= 3'd3) begin
                pp_next  = WIDE'(half_a) * WIDE'(half_b);
                pos_next = {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
            end
            if (step_reg >= 3'd1 && step_reg <= 3'd4) begin
                prod_next = prod_reg + ({{WIDE{1'b0}}, pp_reg} << {pos_reg, 5'd0});
            end
            if (step_reg == 3'd5) begin
                res_next  = neg_reg ? WIDE'(-lo) : lo;
                sat_next  = over;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        neg_reg    <= neg_next;
        narrow_reg <= narrow_next;
        prod_reg   <= prod_next;
        pp_reg     <= pp_next;
        pos_reg    <= pos_next;
        res_reg    <= res_next;
        sat_reg    <= sat_next;
    end

    assign done    = done_reg;
    assign res     = res_reg;
    assign res_sat = sat_reg;

endmodule

### design/mi4_datapath.sv
// ----------------------------------------------------------------------------
// mi4_datapath: storage and arithmetic of the matrix inverter
// Matrix and cofactor RAMs, the shared multiplier, the cofactor and
// determinant accumulators, the reciprocal divider and the output register.
// ----------------------------------------------------------------------------
module mi4_datapath #(
    parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mi4_pkg::cmd_t                cmd,
    output mi4_pkg::status_t             status,
    input  logic signed [DATA_WIDTH-1:0] elem_value,
    output logic signed [DATA_WIDTH-1:0] inv_value,
    output logic                         singular,
    output logic                         saturated,
    output logic                         last
);
    import mi4_pkg::*;

    localparam int QW = 63;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

    logic [3:0]            mat_a_addr;
    logic [3:0]            mat_b_addr;
    logic [3:0]            cof_rd_addr;
    logic [DATA_WIDTH-1:0] mat_a_rdata;
    logic [DATA_WIDTH-1:0] mat_b_rdata;
    logic [WIDE:0]         cof_rdata;
    logic [WIDE:0]         cof_wdata;
    logic signed [WIDE-1:0] elem_a;
    logic signed [WIDE-1:0] elem_b;
    logic signed [WIDE-1:0] cof_val;
    logic                  cof_sat;
    logic signed [WIDE-1:0] mul_a;
    logic signed [WIDE-1:0] mul_b;
    logic signed [WIDE-1:0] mul_res;
    logic                  mul_sat;
    logic                  mul_done;
    logic signed [WIDE-1:0] recip;
    step_info_t            si;
    sat_val_t              sv;
    sat_val_t              negv;
    logic [WIDE:0]         rem_shift;
    logic                  odd;

    logic signed [WIDE-1:0] p_reg, p_next;
    logic signed [WIDE-1:0] d_reg, d_next;
    logic signed [WIDE-1:0] t_reg, t_next;
    logic                   csat_reg, csat_next;
    logic signed [WIDE-1:0] det_reg, det_next;
    logic                   dsat_reg, dsat_next;
    logic [WIDE-1:0]        dvs_reg, dvs_next;
    logic [WIDE:0]          rem_reg, rem_next;
    logic [QW-1:0]          q_reg, q_next;
    logic [CNT_W-1:0]       dcnt_reg, dcnt_next;
    logic signed [DATA_WIDTH-1:0] oval_reg, oval_next;
    logic                   osing_reg, osing_next;
    logic                   osat_reg, osat_next;
    logic                   olast_reg, olast_next;

    // compute read addresses and operands per phase
    always_comb begin
        si          = step_info(cmd.mstep);
        mat_a_addr  = minor_addr(cmd.idx[3:2], cmd.idx[1:0], si.ia, si.ja);
        mat_b_addr  = minor_addr(cmd.idx[3:2], cmd.idx[1:0], si.ib, si.jb);
        cof_rd_addr = cmd.idx;
        elem_a      = {{(WIDE-DATA_WIDTH){mat_a_rdata[DATA_WIDTH-1]}}, mat_a_rdata};
        elem_b      = {{(WIDE-DATA_WIDTH){mat_b_rdata[DATA_WIDTH-1]}}, mat_b_rdata};
        cof_val     = cof_rdata[WIDE-1:0];
        cof_sat     = cof_rdata[WIDE];
        recip       = det_reg[WIDE-1] ? -WIDE'(q_reg) : WIDE'(q_reg);
        mul_a       = elem_a;
        mul_b       = si.b_is_d ? d_reg : elem_b;
        unique case (cmd.phase)
            PH_COF: begin
            end
            PH_DET: begin
                mat_a_addr = {2'b00, cmd.idx[1:0]};
                mul_b      = cof_val;
            end
            PH_OUT: begin
                cof_rd_addr = {cmd.idx[1:0], cmd.idx[3:2]};
                mul_a       = cof_val;
                mul_b       = recip;
            end
            default: begin
            end
        endcase
    end

    mi4_ram #(.WIDTH(DATA_WIDTH), .DEPTH(16)) u_mat_a (
        .aclk    (aclk),
        .wr_en   (cmd.load_wr),
        .wr_addr (cmd.idx),
        .wr_data (elem_value),
        .rd_addr (mat_a_addr),
        .rd_data (mat_a_rdata)
    );

    mi4_ram #(.WIDTH(DATA_WIDTH), .DEPTH(16)) u_mat_b (
        .aclk    (aclk),
        .wr_en   (cmd.load_wr),
        .wr_addr (cmd.idx),
        .wr_data (elem_value),
        .rd_addr (mat_b_addr),
        .rd_data (mat_b_rdata)
    );

    mi4_ram #(.WIDTH(WIDE + 1), .DEPTH(16)) u_cof (
        .aclk    (aclk),
        .wr_en   (cmd.cof_wr),
        .wr_addr (cmd.idx),
        .wr_data (cof_wdata),
        .rd_addr (cof_rd_addr),
        .rd_data (cof_rdata)
    );

    mi4_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .narrow  (cmd.phase == PH_OUT),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .res     (mul_res),
        .res_sat (mul_sat)
    );

    // accumulate cofactors and determinant, run the divider, load results
    always_comb begin
        p_next     = p_reg;
        d_next     = d_reg;
        t_next     = t_reg;
        csat_next  = csat_reg;
        det_next   = det_reg;
        dsat_next  = dsat_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        dcnt_next  = dcnt_reg;
        oval_next  = oval_reg;
        osing_next = osing_reg;
        osat_next  = osat_reg;
        olast_next = olast_reg;
        odd        = cmd.idx[2] ^ cmd.idx[0];
        sv         = sat_addsub(t_reg, mul_res, si.post == POST_T_SUB);
        negv       = sat_addsub('0, t_reg, 1'b1);
        cof_wdata  = odd ? {csat_reg | negv.sat, negv.value} : {csat_reg, t_reg};
        rem_shift  = {rem_reg[WIDE-1:0], dcnt_reg == '0};

        if (cmd.load_wr) begin
            csat_next = 1'b0;
        end
        if (cmd.post && cmd.phase == PH_COF) begin
            csat_next = csat_reg | mul_sat;
            unique case (si.post)
                POST_P: begin
                    p_next = mul_res;
                end
                POST_D: begin
                    sv        = sat_addsub(p_reg, mul_res, 1'b1);
                    d_next    = sv.value;
                    csat_next = csat_reg | mul_sat | sv.sat;
                end
                POST_T_SET: begin
                    t_next = mul_res;
                end
                POST_T_SUB, POST_T_ADD: begin
                    t_next    = sv.value;
                    csat_next = csat_reg | mul_sat | sv.sat;
                end
                default: begin
                end
            endcase
        end
        if (cmd.cof_wr) begin
            csat_next = 1'b0;
        end
        if (cmd.det_clr) begin
            det_next  = '0;
            dsat_next = 1'b0;
        end
        if (cmd.post && cmd.phase == PH_DET) begin
            sv        = sat_addsub(det_reg, mul_res, 1'b0);
            det_next  = sv.value;
            dsat_next = dsat_reg | cof_sat | mul_sat | sv.sat;
        end
        if (cmd.div_init) begin
            dvs_next  = det_reg[WIDE-1] ? WIDE'(-det_reg) : det_reg;
            rem_next  = '0;
            q_next    = '0;
            dcnt_next = '0;
        end
        if (cmd.div_run) begin
            if (rem_shift >= {1'b0, dvs_reg}) begin
                rem_next = rem_shift - {1'b0, dvs_reg};
                q_next   = {q_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg + CNT_W'(1);
        end
        if (cmd.out_load) begin
            osing_next = det_reg == '0;
            oval_next  = osing_next ? '0 : mul_res[DATA_WIDTH-1:0];
            osat_next  = !osing_next && (dsat_reg | cof_sat | mul_sat);
            olast_next = cmd.idx == 4'd15;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_reg  <= '0;
            dcnt_reg <= '0;
        end else begin
            det_reg  <= det_next;
            dcnt_reg <= dcnt_next;
        end
        p_reg     <= p_next;
        d_reg     <= d_next;
        t_reg     <= t_next;
        csat_reg  <= csat_next;
        dsat_reg  <= dsat_next;
        dvs_reg   <= dvs_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        oval_reg  <= oval_next;
        osing_reg <= osing_next;
        osat_reg  <= osat_next;
        olast_reg <= olast_next;
    end

    assign status.mul_done = mul_done;
    assign status.det_zero = det_reg == '0;
    assign status.div_last = dcnt_reg == CNT_LAST;
    assign inv_value = oval_reg;
    assign singular  = osing_reg;
    assign saturated = osat_reg;
    assign last      = olast_reg;

endmodule

### design/mi4_ctrl.sv
// ----------------------------------------------------------------------------
// mi4_ctrl: sequencer of the matrix inverter
// Steps through loading, the sixteen cofactors, the determinant, the
// reciprocal and the sixteen result items.
// ----------------------------------------------------------------------------
module mi4_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  mi4_pkg::status_t status,
    output mi4_pkg::cmd_t    cmd
);
    import mi4_pkg::*;

    typedef enum logic [13:0] {
        S_LOAD     = 14'b00000000000001,
        S_COF_RD   = 14'b00000000000010,
        S_COF_MUL  = 14'b00000000000100,
        S_COF_WAIT = 14'b00000000001000,
        S_COF_WR   = 14'b00000000010000,
        S_DET_RD   = 14'b00000000100000,
        S_DET_MUL  = 14'b00000001000000,
        S_DET_WAIT = 14'b00000010000000,
        S_DIV_INIT = 14'b00000100000000,
        S_DIV_RUN  = 14'b00001000000000,
        S_OUT_RD   = 14'b00010000000000,
        S_OUT_MUL  = 14'b00100000000000,
        S_OUT_WAIT = 14'b01000000000000,
        S_OUT_HOLD = 14'b10000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [3:0] mstep_reg, mstep_next;

    // advance the sequence
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        mstep_next = mstep_reg;
        cmd           = '0;
        cmd.phase     = PH_COF;
        cmd.idx       = idx_reg;
        cmd.mstep     = mstep_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    cmd.load_wr = 1'b1;
                    idx_next    = idx_reg + 4'd1;
                    if (idx_reg == 4'd15) begin
                        mstep_next = '0;
                        state_next = S_COF_RD;
                    end
                end
            end
            S_COF_RD: begin
                state_next = S_COF_MUL;
            end
            S_COF_MUL: begin
                cmd.mul_start = 1'b1;
                state_next    = S_COF_WAIT;
            end
            S_COF_WAIT: begin
                if (status.mul_done) begin
                    cmd.post = 1'b1;
                    if (mstep_reg == LAST_MSTEP) begin
                        state_next = S_COF_WR;
                    end else begin
                        mstep_next = mstep_reg + 4'd1;
                        state_next = S_COF_RD;
                    end
                end
            end
            S_COF_WR: begin
                cmd.cof_wr = 1'b1;
                mstep_next = '0;
                idx_next   = idx_reg + 4'd1;
                if (idx_reg == 4'd15) begin
                    cmd.det_clr = 1'b1;
                    state_next  = S_DET_RD;
                end else begin
                    state_next = S_COF_RD;
                end
            end
            S_DET_RD: begin
                cmd.phase  = PH_DET;
                state_next = S_DET_MUL;
            end
            S_DET_MUL: begin
                cmd.phase     = PH_DET;
                cmd.mul_start = 1'b1;
                state_next    = S_DET_WAIT;
            end
            S_DET_WAIT: begin
                cmd.phase = PH_DET;
                if (status.mul_done) begin
                    cmd.post = 1'b1;
                    if (idx_reg == 4'd3) begin
                        idx_next   = '0;
                        state_next = S_DIV_INIT;
                    end else begin
                        idx_next   = idx_reg + 4'd1;
                        state_next = S_DET_RD;
                    end
                end
            end
            S_DIV_INIT: begin
                cmd.phase    = PH_OUT;
                cmd.div_init = 1'b1;
                state_next   = status.det_zero ? S_OUT_RD : S_DIV_RUN;
            end
            S_DIV_RUN: begin
                cmd.phase   = PH_OUT;
                cmd.div_run = 1'b1;
                if (status.div_last) begin
                    state_next = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                cmd.phase  = PH_OUT;
                state_next = S_OUT_MUL;
            end
            S_OUT_MUL: begin
                cmd.phase     = PH_OUT;
                cmd.mul_start = 1'b1;
                state_next    = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                cmd.phase = PH_OUT;
                if (status.mul_done) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_OUT_HOLD;
                end
            end
            S_OUT_HOLD: begin
                cmd.phase = PH_OUT;
                if (m_ready) begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = (idx_reg == 4'd15) ? S_LOAD : S_OUT_RD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            idx_reg   <= '0;
            mstep_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            mstep_reg <= mstep_next;
        end
    end

    assign s_ready = state_reg == S_LOAD;
    assign m_valid = state_reg == S_OUT_HOLD;

    // input and result sides are never open together
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels open together");

    // a product only finishes while a wait state expects it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        status.mul_done |-> (state_reg == S_COF_WAIT || state_reg == S_DET_WAIT ||
                             state_reg == S_OUT_WAIT))
        else $error("multiplier finished outside a wait state");

    // the sixteenth item taken in a load starts the cofactor work
    a_load_to_cof: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && idx_reg == 4'd15) |=> (state_reg == S_COF_RD &&
                                                      idx_reg == 4'd0))
        else $error("run did not start after sixteenth item");

    // the last result item returns to loading
    a_out_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && idx_reg == 4'd15) |=> s_ready)
        else $error("block did not return to loading after last item");

endmodule
